### sv/arr_pkg.sv
package arr_pkg;

    // Flags from the compare unit
    typedef struct packed {
        logic empty;     // store holds no value
        logic full;      // store holds STORE_DEPTH values
        logic greater;   // sample is strictly greater than the top value
    } arr_cmp_t;

endpackage

### sv/ascending_run_reverser_top.sv
// Ascending run reverser: pushes values while they ascend, drains each run top first.
// Each drained word passes through a RAM read state and an output load state; a push writes directly.
// Throughput: one word per cycle while no run breaks or line ends; a run break or end-of-line
// flush stalls the input while the run drains (and a breaking item is pushed), longer under
// output stalls, set by the single read port of the run store and the serial drain sequencer.
// Reset: rst_n clears the sequencer, fill count and output valid; the store is not cleared.
module ascending_run_reverser_top #(
    parameter int STORE_DEPTH = 32,
    parameter int VALUE_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         end_of_line,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] run_value,
    output logic                         run_end,
    output logic                         forced_split,
    output logic                         line_end,
    output logic                         last_result
);

    import arr_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_PUSH
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [VALUE_BITS-1:0]   top_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic                    eol_reg;
    logic                    drain_forced_reg;
    logic                    drain_eol_reg;
    logic                    out_valid_reg;
    logic [VALUE_BITS-1:0]   run_value_reg;
    logic                    run_end_reg;
    logic                    forced_split_reg;
    logic                    line_end_reg;
    logic                    last_result_reg;

    arr_cmp_t                flags;
    logic                    accept;
    logic                    slot_free;
    logic                    direct_push;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VALUE_BITS-1:0]   ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [VALUE_BITS-1:0]   ram_rdata;
    logic [CW-1:0]           count_m1;
    logic                    last_of_run;

    arr_cmp #(
        .VALUE_BITS  (VALUE_BITS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_cmp (
        .sample (sample_value),
        .top    (top_reg),
        .count  (count_reg),
        .flags  (flags)
    );

    arr_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and store access
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        accept      = in_valid && (state_reg == ST_IDLE);
        slot_free   = !out_valid_reg || !out_stall;
        direct_push = flags.empty || (flags.greater && !flags.full);
        count_m1    = count_reg - CW'(1);
        last_of_run = (count_reg == CW'(1));
        ram_raddr   = count_m1[AW-1:0];
        ram_we      = (accept && direct_push) || (state_reg == ST_PUSH);
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = (state_reg == ST_PUSH) ? val_reg : sample_value;
    end

    // Sequencer, fill count and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            drain_forced_reg <= 1'b0;
            drain_eol_reg    <= 1'b0;
            eol_reg          <= 1'b0;
        end
        else
        begin
            // load a new output word, or drop the current one once it is taken
            if ((state_reg == ST_DRAIN_OUT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg <= sample_value;
                        eol_reg <= end_of_line;
                        if (direct_push)
                        begin
                            top_reg   <= sample_value;
                            count_reg <= count_reg + CW'(1);
                            if (end_of_line)
                            begin
                                drain_forced_reg <= 1'b0;
                                drain_eol_reg    <= 1'b1;
                                state_reg        <= ST_DRAIN_RD;
                            end
                        end
                        else
                        begin
                            // run break, forced when the sample still ascends
                            drain_forced_reg <= flags.greater;
                            drain_eol_reg    <= 1'b0;
                            state_reg        <= ST_DRAIN_RD;
                        end
                    end
                end

                ST_DRAIN_RD:
                begin
                    state_reg <= ST_DRAIN_OUT;
                end

                ST_DRAIN_OUT:
                begin
                    if (slot_free)
                    begin
                        run_value_reg    <= ram_rdata;
                        run_end_reg      <= last_of_run;
                        forced_split_reg <= drain_forced_reg;
                        line_end_reg     <= last_of_run && drain_eol_reg;
                        last_result_reg  <= last_of_run && (drain_eol_reg || !eol_reg);
                        count_reg        <= count_m1;
                        if (last_of_run)
                        begin
                            state_reg <= drain_eol_reg ? ST_IDLE : ST_PUSH;
                        end
                        else
                        begin
                            state_reg <= ST_DRAIN_RD;
                        end
                    end
                end

                ST_PUSH:
                begin
                    top_reg   <= val_reg;
                    count_reg <= CW'(1);
                    if (eol_reg)
                    begin
                        drain_forced_reg <= 1'b0;
                        drain_eol_reg    <= 1'b1;
                        state_reg        <= ST_DRAIN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the output ports
    assign out_valid    = out_valid_reg;
    assign run_value    = run_value_reg;
    assign run_end      = run_end_reg;
    assign forced_split = forced_split_reg;
    assign line_end     = line_end_reg;
    assign last_result  = last_result_reg;

endmodule

### sv/arr_ram.sv
module arr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/arr_cmp.sv
module arr_cmp #(
    parameter int VALUE_BITS  = 16,
    parameter int STORE_DEPTH = 32
) (
    input  logic signed [VALUE_BITS-1:0]        sample,
    input  logic signed [VALUE_BITS-1:0]        top,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]    count,
    output arr_pkg::arr_cmp_t                   flags
);

    import arr_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH + 1);

    // Compare the sample against the top value and the fill level
    always_comb
    begin
        flags.greater = (sample > top);
        flags.empty   = (count == '0);
        flags.full    = (count >= CW'(STORE_DEPTH));
    end

endmodule
